### src/gbn_pkg.sv
// Shared types and constants for the greedy box suppression block.
package gbn_pkg;

	localparam int CORNER_W = 16;
	localparam int AREA_W = 32;
	localparam int LIMIT_W = 17;
	localparam int RANK_W = 6;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 17;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [LIMIT_W-1:0] limit_t;

	localparam cfg_idx_t CFG_IOU_LIMIT = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_SIZE_OFFSET = cfg_idx_t'(1);

	localparam limit_t LIMIT_RESET = limit_t'(32768);

	typedef struct packed {
		logic signed [CORNER_W-1:0] left;
		logic signed [CORNER_W-1:0] top;
		logic signed [CORNER_W-1:0] right;
		logic signed [CORNER_W-1:0] bottom;
		logic [AREA_W-1:0] area;
	} box_t;

	typedef struct packed {
		limit_t limit;
		logic offset;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic hit;
		logic busy;
	} iou_res_t;

endpackage

### src/gbn_if.sv
// Handshake channel interfaces for boxes in, keep flags out and register writes.
interface gbn_box_if;
	logic valid;
	logic ready;
	logic signed [gbn_pkg::CORNER_W-1:0] left;
	logic signed [gbn_pkg::CORNER_W-1:0] top;
	logic signed [gbn_pkg::CORNER_W-1:0] right;
	logic signed [gbn_pkg::CORNER_W-1:0] bottom;
	logic [gbn_pkg::AREA_W-1:0] box_area;
	logic final_box;

	modport source(output valid, left, top, right, bottom, box_area, final_box, input ready);
	modport sink(input valid, left, top, right, bottom, box_area, final_box, output ready);
endinterface

interface gbn_flag_if;
	logic valid;
	logic ready;
	logic [gbn_pkg::RANK_W-1:0] rank;
	logic keep;
	logic overflowed;
	logic end_of_run;

	modport source(output valid, rank, keep, overflowed, end_of_run, input ready);
	modport sink(input valid, rank, keep, overflowed, end_of_run, output ready);
endinterface

interface gbn_cfg_if;
	logic valid;
	logic ready;
	logic [gbn_pkg::CFG_IDX_W-1:0] index;
	logic [gbn_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### src/gbn_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module gbn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/gbn_iou.sv
// Pipelined overlap test of a pivot box against a candidate box, without division.
module gbn_iou #(
	parameter int TAG_W = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic valid,
	input  logic [TAG_W-1:0] tag,
	input  gbn_pkg::box_t pivot,
	input  gbn_pkg::box_t cand,
	input  gbn_pkg::cfg_t cfg,
	output gbn_pkg::iou_res_t res,
	output logic [TAG_W-1:0] res_tag
);

	localparam int DIM_W = gbn_pkg::CORNER_W + 1;
	localparam int INTER_W = 2 * DIM_W;
	localparam int SUM_W = gbn_pkg::AREA_W + 1;
	localparam int UNI_W = INTER_W + 2;
	localparam int PROD_W = gbn_pkg::LIMIT_W + SUM_W;

	logic signed [gbn_pkg::CORNER_W-1:0] lo_x, lo_y, hi_x, hi_y;
	logic signed [DIM_W:0] w_raw, h_raw, add;

	logic valid_s2, valid_s3, valid_s4, valid_s5;
	logic [TAG_W-1:0] tag_s2, tag_s3, tag_s4, tag_s5;
	logic [DIM_W-1:0] w_s2, h_s2;
	logic [gbn_pkg::AREA_W-1:0] area_a_s2, area_b_s2;
	logic [INTER_W-1:0] inter_s3, inter_s4, inter_s5;
	logic [SUM_W-1:0] sum_s3;
	logic signed [UNI_W-1:0] uni_s4;
	logic [PROD_W-1:0] prod_s5;
	logic uni_pos_s5, uni_zero_s5;
	logic [PROD_W-1:0] scaled;

	always_comb begin
		lo_x = ($signed(pivot.left) > $signed(cand.left)) ? pivot.left : cand.left;
		lo_y = ($signed(pivot.top) > $signed(cand.top)) ? pivot.top : cand.top;
		hi_x = ($signed(pivot.right) < $signed(cand.right)) ? pivot.right : cand.right;
		hi_y = ($signed(pivot.bottom) < $signed(cand.bottom)) ? pivot.bottom : cand.bottom;
		add = cfg.offset ? (DIM_W+1)'(16) : '0;
		w_raw = (DIM_W+1)'(hi_x) - (DIM_W+1)'(lo_x) + add;
		h_raw = (DIM_W+1)'(hi_y) - (DIM_W+1)'(lo_y) + add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s2 <= valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2 <= tag;
		w_s2 <= w_raw[DIM_W] ? '0 : w_raw[DIM_W-1:0];
		h_s2 <= h_raw[DIM_W] ? '0 : h_raw[DIM_W-1:0];
		area_a_s2 <= pivot.area;
		area_b_s2 <= cand.area;

		tag_s3 <= tag_s2;
		inter_s3 <= INTER_W'(w_s2) * INTER_W'(h_s2);
		sum_s3 <= SUM_W'(area_a_s2) + SUM_W'(area_b_s2);

		tag_s4 <= tag_s3;
		inter_s4 <= inter_s3;
		uni_s4 <= $signed(UNI_W'(sum_s3)) - $signed(UNI_W'(inter_s3));

		tag_s5 <= tag_s4;
		inter_s5 <= inter_s4;
		prod_s5 <= PROD_W'(cfg.limit) * PROD_W'(uni_s4[SUM_W-1:0]);
		uni_pos_s5 <= (uni_s4 > 0);
		uni_zero_s5 <= (uni_s4 == 0);
	end

	always_comb begin
		scaled = {inter_s5, 16'b0};
		res.valid = valid_s5;
		res.busy = valid_s2 | valid_s3 | valid_s4 | valid_s5;
		if (uni_pos_s5) begin
			res.hit = (scaled >= prod_s5);
		end else if (uni_zero_s5) begin
			res.hit = (inter_s5 != '0);
		end else begin
			res.hit = (inter_s5 == '0) && (cfg.limit == '0);
		end
	end

	assign res_tag = tag_s5;

endmodule

### src/greedy_box_nms.sv
// Top level of the greedy IoU box suppression block: box store, sequencer and flag output.
//
//  Channel  Direction  Payload                                   Transaction when
//  boxes    in         left top right bottom box_area final_box  valid && ready
//  flags    out        rank keep overflowed end_of_run           valid && ready
//  cfg      in         index data                                valid && ready
//
// A final box starts suppression: for every rank i still kept, the scan and pivot
// states fetch box i, the sweep state streams later boxes through the read port of
// the box memories, and the drain state empties the overlap pipeline; ranks already
// suppressed are skipped in the scan state. Then one flag per stored box leaves at
// up to one per cycle. No clearing pass follows reset; keep flags are flip-flops.
// A stalled flags channel holds the emitter; boxes are refused until the set is out.
module greedy_box_nms #(
	parameter int MAX_BOXES = 64
) (
	input  logic clk,
	input  logic arst_n,
	gbn_box_if.sink boxes,
	gbn_flag_if.source flags,
	gbn_cfg_if.sink cfg
);

	localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int CRN_W = 4 * gbn_pkg::CORNER_W;

	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_PIVOT = 6'b000100,
		ST_SWEEP = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t state_q;
	gbn_pkg::cfg_t cfg_q;
	logic [CNT_W-1:0] count_q, i_q, j_q, e_q;
	logic [CNT_W-1:0] e_next;
	logic drop_q;
	logic [MAX_BOXES-1:0] keep_q;
	gbn_pkg::box_t pivot_q;
	logic rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic flag_valid_q;
	gbn_pkg::rank_t flag_rank_q;
	logic flag_keep_q, flag_drop_q, flag_end_q;

	logic box_acc, store_we, out_free;
	logic [IDX_W-1:0] raddr;
	logic [CRN_W-1:0] crn_rdata;
	logic [gbn_pkg::AREA_W-1:0] area_rdata;
	gbn_pkg::box_t rd_box;
	gbn_pkg::iou_res_t res;
	logic [IDX_W-1:0] res_tag;

	assign boxes.ready = (state_q == ST_LOAD);
	assign box_acc = boxes.valid && boxes.ready;
	assign store_we = box_acc && (count_q < CNT_W'(MAX_BOXES));
	assign cfg.ready = 1'b1;
	assign out_free = !flag_valid_q || flags.ready;
	assign e_next = e_q + CNT_W'(1);

	assign flags.valid = flag_valid_q;
	assign flags.rank = flag_rank_q;
	assign flags.keep = flag_keep_q;
	assign flags.overflowed = flag_drop_q;
	assign flags.end_of_run = flag_end_q;

	always_comb begin
		raddr = (state_q == ST_SWEEP) ? j_q[IDX_W-1:0] : i_q[IDX_W-1:0];
		rd_box.left = crn_rdata[4*gbn_pkg::CORNER_W-1:3*gbn_pkg::CORNER_W];
		rd_box.top = crn_rdata[3*gbn_pkg::CORNER_W-1:2*gbn_pkg::CORNER_W];
		rd_box.right = crn_rdata[2*gbn_pkg::CORNER_W-1:gbn_pkg::CORNER_W];
		rd_box.bottom = crn_rdata[gbn_pkg::CORNER_W-1:0];
		rd_box.area = area_rdata;
	end

	gbn_ram #(.WIDTH(CRN_W), .DEPTH(MAX_BOXES)) u_corner_ram (
		.clk(clk),
		.we(store_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata({boxes.left, boxes.top, boxes.right, boxes.bottom}),
		.raddr(raddr),
		.rdata(crn_rdata)
	);

	gbn_ram #(.WIDTH(gbn_pkg::AREA_W), .DEPTH(MAX_BOXES)) u_area_ram (
		.clk(clk),
		.we(store_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(boxes.box_area),
		.raddr(raddr),
		.rdata(area_rdata)
	);

	gbn_iou #(.TAG_W(IDX_W)) u_iou (
		.clk(clk),
		.arst_n(arst_n),
		.valid(rd_valid_s1),
		.tag(rd_idx_s1),
		.pivot(pivot_q),
		.cand(rd_box),
		.cfg(cfg_q),
		.res(res),
		.res_tag(res_tag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit <= gbn_pkg::LIMIT_RESET;
			cfg_q.offset <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				gbn_pkg::CFG_IOU_LIMIT: cfg_q.limit <= cfg.data[gbn_pkg::LIMIT_W-1:0];
				gbn_pkg::CFG_SIZE_OFFSET: cfg_q.offset <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			drop_q <= 1'b0;
			keep_q <= '1;
			i_q <= '0;
			j_q <= '0;
			e_q <= '0;
			rd_valid_s1 <= 1'b0;
			flag_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= 1'b0;
			if (flags.ready) begin
				flag_valid_q <= 1'b0;
			end
			if (res.valid && res.hit) begin
				keep_q[res_tag] <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (box_acc) begin
						if (store_we) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (boxes.final_box) begin
							i_q <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (i_q == count_q) begin
						e_q <= '0;
						state_q <= ST_EMIT;
					end else if (!keep_q[i_q[IDX_W-1:0]]) begin
						i_q <= i_q + CNT_W'(1);
					end else begin
						state_q <= ST_PIVOT;
					end
				end
				ST_PIVOT: begin
					j_q <= i_q + CNT_W'(1);
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (j_q < count_q) begin
						rd_valid_s1 <= 1'b1;
						j_q <= j_q + CNT_W'(1);
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_valid_s1 && !res.busy) begin
						i_q <= i_q + CNT_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						flag_valid_q <= 1'b1;
						e_q <= e_next;
						if (e_next == count_q) begin
							keep_q <= '1;
							count_q <= '0;
							drop_q <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PIVOT) begin
			pivot_q <= rd_box;
		end
		rd_idx_s1 <= j_q[IDX_W-1:0];
		if (state_q == ST_EMIT && out_free) begin
			flag_rank_q <= gbn_pkg::rank_t'(e_q);
			flag_keep_q <= keep_q[e_q[IDX_W-1:0]];
			flag_drop_q <= drop_q;
			flag_end_q <= (e_next == count_q);
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BOXES))
		else $error("Stored box count exceeds capacity.");

	a_res_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
		else $error("Overlap result arrived outside a suppression sweep.");

	a_later_rank: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (CNT_W'(res_tag) > i_q))
		else $error("Overlap result targets a rank not after the pivot.");

	a_read_issued: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(state_q == ST_SWEEP))
		else $error("Candidate read issued outside the sweep state.");
`endif

endmodule
